// File: sv/lbtc_pkg.sv
// ----------------------------------------------------------------------------
// lbtc_pkg
// Shared types and constants of the light facing triangle cull block.
// ----------------------------------------------------------------------------
package lbtc_pkg;

    localparam int RING_INDICES = 3072;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [2:0] CFG_LIGHT_X = 3'd0;
    localparam logic [2:0] CFG_LIGHT_Y = 3'd1;
    localparam logic [2:0] CFG_LIGHT_Z = 3'd2;
    localparam logic [2:0] CFG_MARGIN  = 3'd3;
    localparam logic [2:0] CFG_OFFSET  = 3'd4;

    // result kinds
    localparam logic KIND_KEPT = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // classified triangle, front to back
    typedef struct packed {
        logic        cull;
        logic        batch_end;
        logic [15:0] idx_a;
        logic [15:0] idx_b;
        logic [15:0] idx_c;
    } t_item;

endpackage

// File: sv/lbtc_front.sv
// ----------------------------------------------------------------------------
// lbtc_front
// Six-stage pipeline that classifies each triangle as culled or kept.
// ----------------------------------------------------------------------------
module lbtc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_vert_index_a,
    input  logic [15:0]          i_vert_index_b,
    input  logic [15:0]          i_vert_index_c,
    input  logic [62:0]          i_pos_a,
    input  logic [62:0]          i_pos_b,
    input  logic [62:0]          i_pos_c,
    input  logic [62:0]          i_norm_a,
    input  logic [62:0]          i_norm_b,
    input  logic [62:0]          i_norm_c,
    input  logic                 i_batch_end,
    input  logic signed [20:0]   i_light_x,
    input  logic signed [20:0]   i_light_y,
    input  logic signed [20:0]   i_light_z,
    input  logic [19:0]          i_margin,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lbtc_pkg::t_item      o_item
);

    logic                 en;
    logic [5:0]           r_v;
    lbtc_pkg::t_item      r_meta [6];

    logic signed [20:0]   p [3][3];
    logic signed [20:0]   nv [3][3];
    logic signed [20:0]   lt [3];

    logic signed [21:0]   r_e1 [3];
    logic signed [21:0]   r_e2 [3];
    logic signed [24:0]   r_o1 [3];
    logic signed [21:0]   r_lp [3][3];
    logic signed [20:0]   r_n  [3][3];

    logic signed [43:0]   r_c  [6];
    logic signed [42:0]   r_np [3][3];
    logic signed [24:0]   r_o2 [3];

    logic signed [44:0]   r_f  [3];
    logic [2:0]           r_nok;
    logic signed [24:0]   r_o3 [3];

    logic signed [47:0]   r_ph [3];
    logic signed [47:0]   r_pl [3];
    logic                 r_nall4;

    logic signed [49:0]   r_hs;
    logic signed [49:0]   r_ls;
    logic                 r_nall5;

    logic                 r_cull;

    logic signed [44:0]   nd [3];
    logic signed [45:0]   lim;
    logic signed [71:0]   dsum;

    assign en      = !r_v[5] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[5];

    always_comb begin
        lt[0] = i_light_x;
        lt[1] = i_light_y;
        lt[2] = i_light_z;
        for (int k = 0; k < 3; k++) begin
            p[0][k]  = i_pos_a[21*k +: 21];
            p[1][k]  = i_pos_b[21*k +: 21];
            p[2][k]  = i_pos_c[21*k +: 21];
            nv[0][k] = i_norm_a[21*k +: 21];
            nv[1][k] = i_norm_b[21*k +: 21];
            nv[2][k] = i_norm_c[21*k +: 21];
        end
        lim = 46'($signed({1'b0, i_margin, 19'b0}));
        for (int v = 0; v < 3; v++) begin
            nd[v] = 45'(r_np[v][0]) + 45'(r_np[v][1]) + 45'(r_np[v][2]);
        end
        dsum = (72'(r_hs) <<< 22) + 72'(r_ls);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: edges, three times light minus centroid, light minus vertex
            r_meta[0] <= '{cull: 1'b0, batch_end: i_batch_end, idx_a: i_vert_index_a,
                           idx_b: i_vert_index_b, idx_c: i_vert_index_c};
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= 22'(p[2][k]) - 22'(p[0][k]);
                r_e2[k] <= 22'(p[1][k]) - 22'(p[0][k]);
                r_o1[k] <= 25'(lt[k]) + 25'(lt[k]) + 25'(lt[k])
                         - 25'(p[0][k]) - 25'(p[1][k]) - 25'(p[2][k]);
                for (int v = 0; v < 3; v++) begin
                    r_lp[v][k] <= 22'(lt[k]) - 22'(p[v][k]);
                    r_n[v][k]  <= nv[v][k];
                end
            end
            // stage 2: cross product terms, normal products
            r_c[0] <= 44'(r_e1[1]) * 44'(r_e2[2]);
            r_c[1] <= 44'(r_e1[2]) * 44'(r_e2[1]);
            r_c[2] <= 44'(r_e1[2]) * 44'(r_e2[0]);
            r_c[3] <= 44'(r_e1[0]) * 44'(r_e2[2]);
            r_c[4] <= 44'(r_e1[0]) * 44'(r_e2[1]);
            r_c[5] <= 44'(r_e1[1]) * 44'(r_e2[0]);
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    r_np[v][k] <= 43'(r_n[v][k]) * 43'(r_lp[v][k]);
                end
            end
            r_o2      <= r_o1;
            r_meta[1] <= r_meta[0];
            // stage 3: facing vector, normal tests
            r_f[0] <= 45'(r_c[0]) - 45'(r_c[1]);
            r_f[1] <= 45'(r_c[2]) - 45'(r_c[3]);
            r_f[2] <= 45'(r_c[4]) - 45'(r_c[5]);
            for (int v = 0; v < 3; v++) begin
                r_nok[v] <= (46'(nd[v]) + lim) < 46'sd0;
            end
            r_o3      <= r_o2;
            r_meta[2] <= r_meta[1];
            // stage 4: facing vector split in high and low halves times offset
            for (int k = 0; k < 3; k++) begin
                r_ph[k] <= 48'($signed(r_f[k][44:22])) * 48'(r_o3[k]);
                r_pl[k] <= 48'($signed({1'b0, r_f[k][21:0]})) * 48'(r_o3[k]);
            end
            r_nall4   <= &r_nok;
            r_meta[3] <= r_meta[2];
            // stage 5: partial dot products
            r_hs      <= 50'(r_ph[0]) + 50'(r_ph[1]) + 50'(r_ph[2]);
            r_ls      <= 50'(r_pl[0]) + 50'(r_pl[1]) + 50'(r_pl[2]);
            r_nall5   <= r_nall4;
            r_meta[4] <= r_meta[3];
            // stage 6: threshold -3 * 2^24
            r_cull    <= r_nall5 && (dsum < -72'sd50331648);
            r_meta[5] <= r_meta[4];
        end
    end

    always_comb begin
        o_item      = r_meta[5];
        o_item.cull = r_cull;
    end

endmodule

// File: sv/lbtc_fifo.sv
// ----------------------------------------------------------------------------
// lbtc_fifo
// Short queue of classified triangles between front and back.
// ----------------------------------------------------------------------------
module lbtc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full_n,
    input  lbtc_pkg::t_item  i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output lbtc_pkg::t_item  o_data
);

    lbtc_pkg::t_item                r_mem [lbtc_pkg::Q_DEPTH];
    logic [lbtc_pkg::Q_AW-1:0]      r_wp;
    logic [lbtc_pkg::Q_AW-1:0]      r_rp;
    logic [lbtc_pkg::Q_AW:0]        r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full_n = r_cnt != (lbtc_pkg::Q_AW+1)'(lbtc_pkg::Q_DEPTH);
    assign o_valid  = r_cnt != '0;
    assign o_data   = r_mem[r_rp];
    assign do_push  = i_push && o_full_n;
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (lbtc_pkg::Q_AW+1)'(do_push) - (lbtc_pkg::Q_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: sv/lbtc_back.sv
// ----------------------------------------------------------------------------
// lbtc_back
// Ring sequencer: writes kept triangles and issues draw-range commands.
// ----------------------------------------------------------------------------
module lbtc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  lbtc_pkg::t_item  i_q_data,
    output logic             o_q_pop,
    input  logic [16:0]      i_offset,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_kind,
    output logic [11:0]      o_slot,
    output logic [15:0]      o_out_index_a,
    output logic [15:0]      o_out_index_b,
    output logic [15:0]      o_out_index_c,
    output logic [11:0]      o_draw_base,
    output logic [10:0]      o_draw_triangles,
    output logic [15:0]      o_kept_total,
    output logic             o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FULL = 4'b0010,
        S_KEEP = 4'b0100,
        S_END  = 4'b1000
    } t_state;

    t_state           r_state;
    lbtc_pkg::t_item  r_item;
    logic [11:0]      r_wpos;
    logic [11:0]      r_base;
    logic [15:0]      r_kept;

    logic             out_free;
    logic             over;
    logic             pend;
    logic             load;
    logic [27:0]      tri_prod;
    logic [11:0]      wp_next;

    assign out_free = !o_valid || i_ready;
    assign over     = (13'(r_wpos) + 13'd3) > 13'(lbtc_pkg::RING_INDICES);
    assign pend     = r_wpos != r_base;
    // exact divide by three for multiples of three
    assign tri_prod = 28'(r_wpos - r_base) * 28'd43691;
    assign wp_next  = over ? 12'd0 : r_wpos;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    // a result is loaded into the output register this cycle
    assign load     = out_free && (
                          ((r_state == S_FULL) && !r_item.cull && over && pend) ||
                          ((r_state == S_KEEP) && !r_item.cull) ||
                          ((r_state == S_END) && r_item.batch_end && pend));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wpos  <= '0;
            r_base  <= '0;
            r_kept  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (load) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_data;
                        r_state <= S_FULL;
                    end
                end
                S_FULL: begin
                    if (r_item.cull || !over) begin
                        r_state <= S_KEEP;
                    end else if (!pend || out_free) begin
                        if (pend) begin
                            o_kind           <= lbtc_pkg::KIND_DRAW;
                            o_slot           <= '0;
                            o_out_index_a    <= '0;
                            o_out_index_b    <= '0;
                            o_out_index_c    <= '0;
                            o_draw_base      <= r_base;
                            o_draw_triangles <= tri_prod[27:17];
                            o_kept_total     <= r_kept;
                            o_last           <= 1'b0;
                        end
                        r_wpos  <= '0;
                        r_base  <= '0;
                        r_state <= S_KEEP;
                    end
                end
                S_KEEP: begin
                    if (r_item.cull) begin
                        r_state <= S_END;
                    end else if (out_free) begin
                        o_kind           <= lbtc_pkg::KIND_KEPT;
                        o_slot           <= r_wpos;
                        o_out_index_a    <= r_item.idx_a + i_offset[15:0];
                        o_out_index_b    <= r_item.idx_b + i_offset[15:0];
                        o_out_index_c    <= r_item.idx_c + i_offset[15:0];
                        o_draw_base      <= '0;
                        o_draw_triangles <= '0;
                        o_kept_total     <= (r_kept == 16'hFFFF) ? r_kept : r_kept + 16'd1;
                        o_last           <= !r_item.batch_end;
                        r_kept           <= (r_kept == 16'hFFFF) ? r_kept : r_kept + 16'd1;
                        r_wpos           <= r_wpos + 12'd3;
                        r_state          <= S_END;
                    end
                end
                S_END: begin
                    if (!r_item.batch_end) begin
                        r_state <= S_IDLE;
                    end else if (!pend || out_free) begin
                        if (pend) begin
                            o_kind           <= lbtc_pkg::KIND_DRAW;
                            o_slot           <= '0;
                            o_out_index_a    <= '0;
                            o_out_index_b    <= '0;
                            o_out_index_c    <= '0;
                            o_draw_base      <= r_base;
                            o_draw_triangles <= tri_prod[27:17];
                            o_kept_total     <= r_kept;
                            o_last           <= 1'b1;
                        end
                        r_wpos  <= wp_next;
                        r_base  <= wp_next;
                        r_kept  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/light_backface_triangle_cull_top.sv
// ----------------------------------------------------------------------------
// light_backface_triangle_cull_top
// Culls triangles facing away from a point light and packs kept indices
// into a ring, issuing draw-range commands.
// ----------------------------------------------------------------------------
// A six-stage front pipeline takes one triangle per cycle while a full queue
// does not hold it, and classifies it; a four-entry queue feeds the back
// sequencer, which takes each triangle through its phases (ring-full draw,
// kept write, batch-end draw, fetch) and fetches no new triangle before it
// is through with the last, so that sequencer sets the sustained rate.
// Results leave through a registered output with valid/ready.
module light_backface_triangle_cull_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [20:0]  i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [15:0]  i_vert_index_a,
    input  logic [15:0]  i_vert_index_b,
    input  logic [15:0]  i_vert_index_c,
    input  logic [62:0]  i_pos_a,
    input  logic [62:0]  i_pos_b,
    input  logic [62:0]  i_pos_c,
    input  logic [62:0]  i_norm_a,
    input  logic [62:0]  i_norm_b,
    input  logic [62:0]  i_norm_c,
    input  logic         i_batch_end,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic         o_kind,
    output logic [11:0]  o_slot,
    output logic [15:0]  o_out_index_a,
    output logic [15:0]  o_out_index_b,
    output logic [15:0]  o_out_index_c,
    output logic [11:0]  o_draw_base,
    output logic [10:0]  o_draw_triangles,
    output logic [15:0]  o_kept_total,
    output logic         o_last
);

    logic signed [20:0]  r_light_x;
    logic signed [20:0]  r_light_y;
    logic signed [20:0]  r_light_z;
    logic [19:0]         r_margin;
    logic [16:0]         r_offset;

    logic                f_valid;
    logic                q_full_n;
    logic                q_valid;
    logic                q_pop;
    lbtc_pkg::t_item     f_item;
    lbtc_pkg::t_item     q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
            r_margin  <= '0;
            r_offset  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lbtc_pkg::CFG_LIGHT_X: r_light_x <= i_cfg_data;
                lbtc_pkg::CFG_LIGHT_Y: r_light_y <= i_cfg_data;
                lbtc_pkg::CFG_LIGHT_Z: r_light_z <= i_cfg_data;
                lbtc_pkg::CFG_MARGIN:  r_margin  <= i_cfg_data[19:0];
                lbtc_pkg::CFG_OFFSET:  r_offset  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    lbtc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_vert_index_a (i_vert_index_a),
        .i_vert_index_b (i_vert_index_b),
        .i_vert_index_c (i_vert_index_c),
        .i_pos_a        (i_pos_a),
        .i_pos_b        (i_pos_b),
        .i_pos_c        (i_pos_c),
        .i_norm_a       (i_norm_a),
        .i_norm_b       (i_norm_b),
        .i_norm_c       (i_norm_c),
        .i_batch_end    (i_batch_end),
        .i_light_x      (r_light_x),
        .i_light_y      (r_light_y),
        .i_light_z      (r_light_z),
        .i_margin       (r_margin),
        .o_valid        (f_valid),
        .i_ready        (q_full_n),
        .o_item         (f_item)
    );

    lbtc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid),
        .o_full_n (q_full_n),
        .i_data   (f_item),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_data   (q_item)
    );

    lbtc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (q_item),
        .o_q_pop          (q_pop),
        .i_offset         (r_offset),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_kind           (o_kind),
        .o_slot           (o_slot),
        .o_out_index_a    (o_out_index_a),
        .o_out_index_b    (o_out_index_b),
        .o_out_index_c    (o_out_index_c),
        .o_draw_base      (o_draw_base),
        .o_draw_triangles (o_draw_triangles),
        .o_kept_total     (o_kept_total),
        .o_last           (o_last)
    );

endmodule
